### hdl/mte_pkg.sv
// Package for the multi-turn encoder tracker.
// Holds the field widths, register indexes and fixed-point constants.
// No dependencies.
package mte_pkg;

  localparam int ANGLE_BITS = 14;
  localparam int WORD_W     = 16;
  localparam int TIME_W     = 32;
  localparam int ROT_W      = 18;
  localparam int ABS_W      = ROT_W + ANGLE_BITS;
  localparam int DATA_W     = 32;
  localparam int MIN_W      = 16;
  localparam int STEP_W     = ANGLE_BITS + 1;
  localparam int SUM_W      = DATA_W + 2;
  localparam int SCALE_W    = 20;
  localparam int NUM_W      = DATA_W + SCALE_W;
  localparam int DIV_STEPS  = DATA_W - 1;
  localparam int CNT_W      = 5;
  localparam int IDX_W      = 2;

  localparam logic signed [STEP_W-1:0] HALF_TURN = STEP_W'(1 << (ANGLE_BITS - 1));
  localparam logic signed [ROT_W-1:0]  ROT_MAX   = {1'b0, {(ROT_W-1){1'b1}}};
  localparam logic signed [ROT_W-1:0]  ROT_MIN   = {1'b1, {(ROT_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] S32_MAX   = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S32_MIN   = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [SCALE_W-1:0]       US_PER_S  = SCALE_W'(1000000);

  localparam logic [IDX_W-1:0] REG_DIRECTION = 2'd0;
  localparam logic [IDX_W-1:0] REG_OFFSET    = 2'd1;
  localparam logic [IDX_W-1:0] REG_INTERVAL  = 2'd2;

  localparam logic [MIN_W-1:0] INTERVAL_RESET = MIN_W'(100);

endpackage

### hdl/multiturn_encoder_tracker.sv
// Multi-turn encoder tracker: angle unwrap, offset and serial velocity divider.
// Depends on mte_pkg.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  in       | in_valid / in_ready    | angle_word, time_us
//  out      | out_valid / out_ready  | angle_out, velocity_out, turn_count,
//           |                        | velocity_fresh
//  cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One sample at a time. A sample without a velocity update goes through S_TURN,
// S_ABS and S_EMIT; with an update it also passes S_MUL, S_CHK, the 31-step
// restoring divider (one quotient bit per cycle) and S_SIGN, and S_CHK skips the
// divider when the quotient saturates. in_ready returns as the result is registered.
// A finished result waits in the output register while the next sample is taken.
// rst is synchronous; cfg_ready is always high.
module multiturn_encoder_tracker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [mte_pkg::WORD_W-1:0]         angle_word,
  input  logic [mte_pkg::TIME_W-1:0]         time_us,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [mte_pkg::DATA_W-1:0]  angle_out,
  output logic signed [mte_pkg::DATA_W-1:0]  velocity_out,
  output logic signed [mte_pkg::ROT_W-1:0]   turn_count,
  output logic                               velocity_fresh,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mte_pkg::IDX_W-1:0]          cfg_index,
  input  logic [mte_pkg::DATA_W-1:0]         cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_TURN = 8'b0000_0010,
    S_ABS  = 8'b0000_0100,
    S_MUL  = 8'b0000_1000,
    S_CHK  = 8'b0001_0000,
    S_DIV  = 8'b0010_0000,
    S_SIGN = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_t;

  state_t state;

  logic                                direction_reverse;
  logic signed [mte_pkg::DATA_W-1:0]   angle_offset;
  logic [mte_pkg::MIN_W-1:0]           min_interval_us;

  logic [mte_pkg::ANGLE_BITS-1:0]      raw;
  logic [mte_pkg::TIME_W-1:0]          now;
  logic [mte_pkg::ANGLE_BITS-1:0]      last_raw_angle;
  logic signed [mte_pkg::ROT_W-1:0]    rotations;
  logic signed [mte_pkg::ABS_W-1:0]    prev_abs_angle;
  logic [mte_pkg::TIME_W-1:0]          last_velocity_time;
  logic signed [mte_pkg::DATA_W-1:0]   held_velocity;

  logic signed [mte_pkg::DATA_W-1:0]   angle_res;
  logic                                fresh;
  logic                                neg;
  logic [mte_pkg::DATA_W-1:0]          mag;
  logic [mte_pkg::TIME_W-1:0]          dt;
  logic [mte_pkg::NUM_W-1:0]           num;
  logic [mte_pkg::DATA_W-1:0]          rem;
  logic [mte_pkg::DIV_STEPS-1:0]       quo;
  logic [mte_pkg::CNT_W-1:0]           cnt;

  logic signed [mte_pkg::STEP_W-1:0]   step;
  logic signed [mte_pkg::ABS_W-1:0]    abs_angle;
  logic signed [mte_pkg::SUM_W-1:0]    abs_ext;
  logic signed [mte_pkg::SUM_W-1:0]    sum;
  logic signed [mte_pkg::DATA_W:0]     delta;
  logic [mte_pkg::TIME_W-1:0]          dt_now;
  logic [mte_pkg::DATA_W:0]            rem_shift;
  logic                                rem_ge;
  logic                                emit;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign emit      = (state == S_EMIT) && (!out_valid || out_ready);

  assign step      = $signed({1'b0, raw}) - $signed({1'b0, last_raw_angle});
  assign abs_angle = {rotations, last_raw_angle};
  assign abs_ext   = mte_pkg::SUM_W'(abs_angle);
  assign sum       = (direction_reverse ? -abs_ext : abs_ext)
                     + mte_pkg::SUM_W'(angle_offset);
  assign delta     = $signed({abs_angle[mte_pkg::ABS_W-1], abs_angle})
                     - $signed({prev_abs_angle[mte_pkg::ABS_W-1], prev_abs_angle});
  assign dt_now    = now - last_velocity_time;
  assign rem_shift = {rem, quo[mte_pkg::DIV_STEPS-1]};
  assign rem_ge    = rem_shift >= {1'b0, dt};

  always_ff @(posedge clk) begin
    if (rst) begin
      direction_reverse <= 1'b1;
      angle_offset      <= '0;
      min_interval_us   <= mte_pkg::INTERVAL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mte_pkg::REG_DIRECTION: direction_reverse <= cfg_data[0];
        mte_pkg::REG_OFFSET:    angle_offset      <= $signed(cfg_data);
        mte_pkg::REG_INTERVAL:  min_interval_us   <= cfg_data[mte_pkg::MIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      last_raw_angle     <= '0;
      rotations          <= '0;
      prev_abs_angle     <= '0;
      last_velocity_time <= '0;
      held_velocity      <= '0;
      out_valid          <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            raw   <= angle_word[mte_pkg::ANGLE_BITS-1:0];
            now   <= time_us;
            state <= S_TURN;
          end
        end
        S_TURN: begin
          prev_abs_angle <= abs_angle;
          last_raw_angle <= raw;
          if (step > mte_pkg::HALF_TURN) begin
            if (rotations > mte_pkg::ROT_MIN) rotations <= rotations - mte_pkg::ROT_W'(1);
          end else if (step < -mte_pkg::HALF_TURN) begin
            if (rotations < mte_pkg::ROT_MAX) rotations <= rotations + mte_pkg::ROT_W'(1);
          end
          state <= S_ABS;
        end
        S_ABS: begin
          if (sum[mte_pkg::SUM_W-1:mte_pkg::DATA_W-1] == '0 ||
              sum[mte_pkg::SUM_W-1:mte_pkg::DATA_W-1] == '1) begin
            angle_res <= sum[mte_pkg::DATA_W-1:0];
          end else begin
            angle_res <= sum[mte_pkg::SUM_W-1] ? mte_pkg::S32_MIN : mte_pkg::S32_MAX;
          end
          neg   <= delta[mte_pkg::DATA_W] ^ direction_reverse;
          mag   <= delta[mte_pkg::DATA_W] ? mte_pkg::DATA_W'(-delta)
                                          : delta[mte_pkg::DATA_W-1:0];
          dt    <= dt_now;
          fresh <= 1'b0;
          state <= S_EMIT;
          if (dt_now >= mte_pkg::TIME_W'(min_interval_us) && dt_now != '0) begin
            fresh              <= 1'b1;
            last_velocity_time <= now;
            state              <= S_MUL;
          end
        end
        S_MUL: begin
          num   <= mte_pkg::NUM_W'(mag) * mte_pkg::NUM_W'(mte_pkg::US_PER_S);
          state <= S_CHK;
        end
        S_CHK: begin
          if (mte_pkg::TIME_W'(num[mte_pkg::NUM_W-1:mte_pkg::DIV_STEPS]) >= dt) begin
            held_velocity <= neg ? mte_pkg::S32_MIN : mte_pkg::S32_MAX;
            state         <= S_EMIT;
          end else begin
            rem   <= mte_pkg::DATA_W'(num[mte_pkg::NUM_W-1:mte_pkg::DIV_STEPS]);
            quo   <= num[mte_pkg::DIV_STEPS-1:0];
            cnt   <= mte_pkg::CNT_W'(mte_pkg::DIV_STEPS - 1);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= rem_ge ? mte_pkg::DATA_W'(rem_shift - {1'b0, dt})
                        : rem_shift[mte_pkg::DATA_W-1:0];
          quo <= {quo[mte_pkg::DIV_STEPS-2:0], rem_ge};
          cnt <= cnt - mte_pkg::CNT_W'(1);
          if (cnt == '0) state <= S_SIGN;
        end
        S_SIGN: begin
          held_velocity <= neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
          state         <= S_EMIT;
        end
        S_EMIT: begin
          if (emit) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      angle_out      <= angle_res;
      velocity_out   <= held_velocity;
      turn_count     <= rotations;
      velocity_fresh <= fresh;
    end
  end

endmodule

### hdl/mte_checker.sv
// Port-level checks for the multi-turn encoder tracker, bound to its top level.
// Depends on mte_pkg and multiturn_encoder_tracker.
module mte_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [mte_pkg::DATA_W-1:0]  angle_out,
  input logic signed [mte_pkg::DATA_W-1:0]  velocity_out,
  input logic signed [mte_pkg::ROT_W-1:0]   turn_count,
  input logic                               velocity_fresh
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(angle_out) &&
      $stable(velocity_out) && $stable(turn_count) && $stable(velocity_fresh))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("result appeared too early");

endmodule

bind multiturn_encoder_tracker mte_checker u_mte_checker (.*);
